### hw/rtl/vtsmf_pkg.sv
// ----------------------------------------------------------------------------
// V-tail servo mixer package
// Shared widths, register indexes, reset values and clamp helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package vtsmf_pkg;

    localparam int unsigned PCT_W     = 7;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned GAIN_W    = 11;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 11;
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 56;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAB_CLOSE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAB_OPEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAB_POS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GIMBAL_CTR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEV_GAIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RUDDER_GAIN  = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [CH_W-1:0]   RST_OVERRIDE_THR = 8'd50;
    localparam logic [CH_W-1:0]   RST_REVERSE_THR  = 8'd50;
    localparam logic [CH_W-1:0]   RST_GRAB_CLOSE   = 8'd40;
    localparam logic [CH_W-1:0]   RST_GRAB_OPEN    = 8'd60;
    localparam logic [PCT_W-1:0]  RST_GRAB_POS     = 7'd65;
    localparam logic [PCT_W-1:0]  RST_GIMBAL_CTR   = 7'd50;
    localparam logic [GAIN_W-1:0] RST_ELEV_GAIN    = 11'd717;
    localparam logic [GAIN_W-1:0] RST_RUDDER_GAIN  = 11'd205;

    // Limit a signed mix sum to 0..100.
    function automatic logic [PCT_W-1:0] clamp_s11(input logic signed [10:0] v);
        logic [PCT_W-1:0] r;
        if (v < 11'sd0) begin
            r = '0;
        end else if (v > 11'sd100) begin
            r = PCT_MAX;
        end else begin
            r = v[PCT_W-1:0];
        end
        return r;
    endfunction

    // Limit an unsigned 8-bit reading to 0..100.
    function automatic logic [PCT_W-1:0] clamp_u8(input logic [CH_W-1:0] v);
        logic [PCT_W-1:0] r;
        if (v > 8'd100) begin
            r = PCT_MAX;
        end else begin
            r = v[PCT_W-1:0];
        end
        return r;
    endfunction

    // Limit a 7-bit register value to 0..100.
    function automatic logic [PCT_W-1:0] clamp_u7(input logic [PCT_W-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/vtail_servo_mixer_failsafe.sv
// ----------------------------------------------------------------------------
// V-tail servo mixer with failsafe
// Mixes autopilot or receiver commands into V-tail, aileron, nose wheel,
// throttle, gimbal and grabber servo percentages, with a failsafe override.
// ----------------------------------------------------------------------------
// Path: an accepted input item is held in the input register, then in the result
//   register, which drives the output.
// Throughput: one item per cycle while the output side is ready; the mix is one
//   pass of short logic between the input register and the result register.
// Reset: synchronous, active low; clears both valid flags and the grabber and
//   LED hold state, and loads the configuration registers with their defaults.
`default_nettype none

module vtail_servo_mixer_failsafe
    import vtsmf_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    // Input frame stream.
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata, lowest bit up: ap_elevator[7:0], ap_aileron[15:8], ap_rudder[23:16],
    // rc_elevator[31:24], rc_aileron[39:32], rc_throttle[47:40],
    // rc_rudder[55:48], rc_override[63:56], rc_gimbal[71:64], rc_reverse[79:72]
    input  wire  [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: comms_failed[0]
    input  wire                   i_s_axis_tuser,

    // Servo command stream.
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // tdata, lowest bit up: left_tail[6:0], right_tail[13:7], aileron_out[20:14],
    // nose_wheel[27:21], throttle_out[34:28], gimbal_out[41:35],
    // grabber_out[48:42], reverse_led[49], zero fill [55:50]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,

    // Configuration write channel.
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DAT_W-1:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. The port always accepts a write; writes must happen only
    // while the block is idle (the block does not enforce this), so the mix reads them directly.
    // ------------------------------------------------------------------
    logic [CH_W-1:0]   r_override_thr;
    logic [CH_W-1:0]   r_reverse_thr;
    logic [CH_W-1:0]   r_grab_close;
    logic [CH_W-1:0]   r_grab_open;
    logic [PCT_W-1:0]  r_grab_pos;
    logic [PCT_W-1:0]  r_gimbal_ctr;
    logic [GAIN_W-1:0] r_elev_gain;
    logic [GAIN_W-1:0] r_rudder_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_override_thr <= RST_OVERRIDE_THR;
            r_reverse_thr  <= RST_REVERSE_THR;
            r_grab_close   <= RST_GRAB_CLOSE;
            r_grab_open    <= RST_GRAB_OPEN;
            r_grab_pos     <= RST_GRAB_POS;
            r_gimbal_ctr   <= RST_GIMBAL_CTR;
            r_elev_gain    <= RST_ELEV_GAIN;
            r_rudder_gain  <= RST_RUDDER_GAIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OVERRIDE_THR: r_override_thr <= i_cfg_data[CH_W-1:0];
                CFG_REVERSE_THR:  r_reverse_thr  <= i_cfg_data[CH_W-1:0];
                CFG_GRAB_CLOSE:   r_grab_close   <= i_cfg_data[CH_W-1:0];
                CFG_GRAB_OPEN:    r_grab_open    <= i_cfg_data[CH_W-1:0];
                CFG_GRAB_POS:     r_grab_pos     <= i_cfg_data[PCT_W-1:0];
                CFG_GIMBAL_CTR:   r_gimbal_ctr   <= i_cfg_data[PCT_W-1:0];
                CFG_ELEV_GAIN:    r_elev_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_RUDDER_GAIN:  r_rudder_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. The input register moves into the result register
    // whenever the result register is empty or being drained, so a new item
    // is taken every cycle while the output side keeps up.
    // ------------------------------------------------------------------
    logic                  r_in_valid;
    logic [IN_DATA_W-1:0]  r_in_data;
    logic                  r_in_fail;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  w_advance;
    logic                  w_in_accept;

    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_data <= i_s_axis_tdata;
            r_in_fail <= i_s_axis_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Field extraction from the registered frame.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] w_ap_e, w_ap_a, w_ap_r;
    logic [CH_W-1:0] w_rc_e, w_rc_a, w_rc_t, w_rc_r;
    logic [CH_W-1:0] w_rc_o, w_rc_g, w_rc_v;

    assign w_ap_e = r_in_data[7:0];
    assign w_ap_a = r_in_data[15:8];
    assign w_ap_r = r_in_data[23:16];
    assign w_rc_e = r_in_data[31:24];
    assign w_rc_a = r_in_data[39:32];
    assign w_rc_t = r_in_data[47:40];
    assign w_rc_r = r_in_data[55:48];
    assign w_rc_o = r_in_data[63:56];
    assign w_rc_g = r_in_data[71:64];
    assign w_rc_v = r_in_data[79:72];

    // ------------------------------------------------------------------
    // Source select and V-tail mix. Gains are 1/1024 fixed point; each
    // product is truncated toward zero, which for the left elevator term
    // means working on the magnitude of (100 - elevator) and negating after
    // the shift.
    // ------------------------------------------------------------------
    logic                 w_use_ap;
    logic [CH_W-1:0]      w_e, w_a, w_r;
    logic                 w_left_neg;
    logic [CH_W-1:0]      w_left_mag;
    logic [18:0]          w_prod_left, w_prod_right, w_prod_rud;
    logic signed [10:0]   w_left_term, w_right_term, w_rud_term;
    logic signed [10:0]   w_left_sum, w_right_sum;

    assign w_use_ap   = w_rc_o > r_override_thr;
    assign w_e        = w_use_ap ? w_ap_e : w_rc_e;
    assign w_a        = w_use_ap ? w_ap_a : w_rc_a;
    assign w_r        = w_use_ap ? w_ap_r : w_rc_r;

    assign w_left_neg = w_e > 8'd100;
    assign w_left_mag = w_left_neg ? (w_e - 8'd100) : (8'd100 - w_e);

    assign w_prod_left  = 19'(r_elev_gain) * 19'(w_left_mag);
    assign w_prod_right = 19'(r_elev_gain) * 19'(w_e);
    assign w_prod_rud   = 19'(r_rudder_gain) * 19'(w_r);

    assign w_left_term  = w_left_neg ? -$signed({2'b00, w_prod_left[18:10]})
                                     :  $signed({2'b00, w_prod_left[18:10]});
    assign w_right_term = $signed({2'b00, w_prod_right[18:10]});
    assign w_rud_term   = $signed({2'b00, w_prod_rud[18:10]});

    assign w_left_sum  = w_left_term + w_rud_term;
    assign w_right_sum = w_right_term + w_rud_term;

    // ------------------------------------------------------------------
    // Grabber, gimbal and reverse indicator. The grabber and the LED keep
    // their last values; a failsafe frame shows them without changing them.
    // ------------------------------------------------------------------
    logic [PCT_W-1:0] r_grab_hold, n_grab_hold;
    logic             r_led_hold, n_led_hold;
    logic [PCT_W-1:0] w_centre;
    logic [PCT_W-1:0] w_gimbal;
    logic [OUT_DATA_W-1:0] n_out_data;

    assign w_centre = clamp_u7(r_gimbal_ctr);

    always_comb begin
        n_grab_hold = r_grab_hold;
        n_led_hold  = r_led_hold;
        w_gimbal    = clamp_u8(w_rc_g);
        if (!r_in_fail) begin
            n_led_hold = w_rc_v > r_reverse_thr;
            if (w_rc_g < r_grab_close) begin
                n_grab_hold = '0;
                w_gimbal    = w_centre;
            end else if (w_rc_g > r_grab_open) begin
                n_grab_hold = clamp_u7(r_grab_pos);
                w_gimbal    = w_centre;
            end
        end
    end

    always_comb begin
        if (r_in_fail) begin
            n_out_data = {6'b0, r_led_hold, r_grab_hold, w_centre,
                          7'd0, 7'd0, PCT_MAX, PCT_MAX, 7'd0};
        end else begin
            n_out_data = {6'b0, n_led_hold, n_grab_hold, w_gimbal,
                          clamp_u8(w_rc_t),
                          (w_rc_r >= 8'd100) ? 7'd0 : 7'(8'd100 - w_rc_r),
                          clamp_u8(w_a),
                          clamp_s11(w_right_sum),
                          clamp_s11(w_left_sum)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grab_hold <= '0;
            r_led_hold  <= 1'b0;
        end else if (r_in_valid && w_advance) begin
            r_grab_hold <= n_grab_hold;
            r_led_hold  <= n_led_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/vtsmf_checker.sv
// ----------------------------------------------------------------------------
// V-tail servo mixer port checker
// Port-level checks on the mixer's input and output streams, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vtsmf_checker
    import vtsmf_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_axis_tvalid,
    input wire                   o_s_axis_tready,
    input wire                   o_m_axis_tvalid,
    input wire                   i_m_axis_tready,
    input wire [OUT_DATA_W-1:0]  o_m_axis_tdata
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result item changed");

    // No result item is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Every servo percentage is in 0..100 and the fill bits are zero.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[6:0] <= PCT_MAX && o_m_axis_tdata[13:7] <= PCT_MAX &&
            o_m_axis_tdata[20:14] <= PCT_MAX && o_m_axis_tdata[27:21] <= PCT_MAX &&
            o_m_axis_tdata[34:28] <= PCT_MAX && o_m_axis_tdata[41:35] <= PCT_MAX &&
            o_m_axis_tdata[48:42] <= PCT_MAX && o_m_axis_tdata[55:50] == 6'd0)
        else $error("servo percentage out of range");

    // An item taken while the output stalls fills the input register, so a
    // stall that persists must close the input side.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && o_m_axis_tvalid && !i_m_axis_tready
            |=> i_m_axis_tready || !o_s_axis_tready)
        else $error("input accepted past a full pipeline");

endmodule

bind vtail_servo_mixer_failsafe vtsmf_checker u_vtsmf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

### dv/vtail_servo_mixer_failsafe_tb.sv
// ----------------------------------------------------------------------------
// V-tail servo mixer testbench
// Streams control frames through the mixer under several register settings,
// with random idling on both sides and a long output hold-off, and checks
// every servo command item field by field against a mixer model kept here.
// ----------------------------------------------------------------------------
`default_nettype none

module vtail_servo_mixer_failsafe_tb;
    import vtsmf_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_AT     = 150;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 40;

    // One control frame as it enters the block.
    typedef struct packed {
        logic            comms_failed;
        logic [CH_W-1:0] ap_elevator;
        logic [CH_W-1:0] ap_aileron;
        logic [CH_W-1:0] ap_rudder;
        logic [CH_W-1:0] rc_elevator;
        logic [CH_W-1:0] rc_aileron;
        logic [CH_W-1:0] rc_throttle;
        logic [CH_W-1:0] rc_rudder;
        logic [CH_W-1:0] rc_override;
        logic [CH_W-1:0] rc_gimbal;
        logic [CH_W-1:0] rc_reverse;
    } t_frame;

    // One set of servo commands as it leaves the block.
    typedef struct packed {
        logic [PCT_W-1:0] left_tail;
        logic [PCT_W-1:0] right_tail;
        logic [PCT_W-1:0] aileron_out;
        logic [PCT_W-1:0] nose_wheel;
        logic [PCT_W-1:0] throttle_out;
        logic [PCT_W-1:0] gimbal_out;
        logic [PCT_W-1:0] grabber_out;
        logic             reverse_led;
    } t_servo_cmd;

    // Every input of the block starts at a known value.
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_s_axis_tuser  = 1'b0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_OVERRIDE_THR;
    logic [CFG_DAT_W-1:0]  i_cfg_data      = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_cfg_ready;

    // Mirror of the block's registers and hold state, updated as items are
    // accepted and registers are written.
    logic [CH_W-1:0]   ovr_thr     = RST_OVERRIDE_THR;
    logic [CH_W-1:0]   rev_thr     = RST_REVERSE_THR;
    logic [CH_W-1:0]   close_below = RST_GRAB_CLOSE;
    logic [CH_W-1:0]   open_above  = RST_GRAB_OPEN;
    logic [PCT_W-1:0]  open_pos    = RST_GRAB_POS;
    logic [PCT_W-1:0]  centre_pos  = RST_GIMBAL_CTR;
    logic [GAIN_W-1:0] elev_gain   = RST_ELEV_GAIN;
    logic [GAIN_W-1:0] rud_gain    = RST_RUDDER_GAIN;
    logic [PCT_W-1:0]  grabber_state = '0;
    logic              led_state     = 1'b0;

    t_frame     pending_frames[$];
    t_servo_cmd expected_cmds[$];

    // Idling controls. The stimulus process switches idling off for the last
    // part of the run; the hold-off is started and counted by the monitor.
    logic send_idle_en = 1'b1;
    logic recv_idle_en = 1'b1;
    int   send_gap     = 0;
    int   recv_gap     = 0;
    int   hold_cnt     = 0;
    logic hold_done    = 1'b0;
    int   results_seen = 0;
    int   quiet_cycles = 0;
    int   fails        = 0;

    vtail_servo_mixer_failsafe dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Mixer model
    // ------------------------------------------------------------------------

    function automatic logic [PCT_W-1:0] pct_limit(input int v);
        logic [PCT_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 100) begin
            r = PCT_MAX;
        end else begin
            r = PCT_W'(v);
        end
        return r;
    endfunction

    // Gain in 1/1024 units; integer division truncates toward zero, which is
    // what the mix needs for negative elevator terms.
    function automatic int gain_scale(input int gain, input int value);
        return (gain * value) / 1024;
    endfunction

    // Works out the servo commands for one accepted frame and advances the
    // grabber and LED hold state. A comms failure leaves the hold state alone.
    function automatic t_servo_cmd mix_frame(input t_frame f);
        t_servo_cmd       c;
        logic             use_ap;
        int               e;
        int               a;
        int               r;
        int               rud;
        logic [PCT_W-1:0] centre;
        logic [PCT_W-1:0] gim;
        centre = pct_limit(int'(centre_pos));
        if (f.comms_failed) begin
            c.left_tail    = '0;
            c.right_tail   = PCT_MAX;
            c.aileron_out  = PCT_MAX;
            c.nose_wheel   = '0;
            c.throttle_out = '0;
            c.gimbal_out   = centre;
            c.grabber_out  = grabber_state;
            c.reverse_led  = led_state;
        end else begin
            use_ap = f.rc_override > ovr_thr;
            e = use_ap ? int'(f.ap_elevator) : int'(f.rc_elevator);
            a = use_ap ? int'(f.ap_aileron)  : int'(f.rc_aileron);
            r = use_ap ? int'(f.ap_rudder)   : int'(f.rc_rudder);
            rud = gain_scale(int'(rud_gain), r);
            gim = pct_limit(int'(f.rc_gimbal));
            led_state = f.rc_reverse > rev_thr;
            // Between the two gimbal thresholds the grabber keeps its value.
            if (f.rc_gimbal < close_below) begin
                grabber_state = '0;
                gim = centre;
            end else if (f.rc_gimbal > open_above) begin
                grabber_state = pct_limit(int'(open_pos));
                gim = centre;
            end
            c.left_tail    = pct_limit(gain_scale(int'(elev_gain), 100 - e) + rud);
            c.right_tail   = pct_limit(gain_scale(int'(elev_gain), e) + rud);
            c.aileron_out  = pct_limit(a);
            // The nose wheel always follows the receiver rudder.
            c.nose_wheel   = pct_limit(100 - int'(f.rc_rudder));
            c.throttle_out = pct_limit(int'(f.rc_throttle));
            c.gimbal_out   = gim;
            c.grabber_out  = grabber_state;
            c.reverse_led  = led_state;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly in the nominal percent range, with a fair share of out-of-range
    // readings and the two extremes.
    function automatic logic [CH_W-1:0] rand_level();
        logic [CH_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = CH_W'($urandom_range(101, 255));
            default: v = CH_W'($urandom_range(0, 100));
        endcase
        return v;
    endfunction

    // A reading close to a threshold, so that both sides of each compare
    // are hit often.
    function automatic logic [CH_W-1:0] near_level(input logic [CH_W-1:0] thr);
        int v;
        if ($urandom_range(0, 3) == 0) begin
            v = int'(rand_level());
        end else begin
            v = int'(thr) + int'($urandom_range(0, 4)) - 2;
        end
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return CH_W'(v);
    endfunction

    function automatic t_frame rand_frame();
        t_frame f;
        f.comms_failed = ($urandom_range(0, 7) == 0);
        f.ap_elevator  = rand_level();
        f.ap_aileron   = rand_level();
        f.ap_rudder    = rand_level();
        f.rc_elevator  = rand_level();
        f.rc_aileron   = rand_level();
        f.rc_throttle  = rand_level();
        f.rc_rudder    = rand_level();
        f.rc_override  = near_level(ovr_thr);
        f.rc_reverse   = near_level(rev_thr);
        case ($urandom_range(0, 2))
            0:       f.rc_gimbal = near_level(close_below);
            1:       f.rc_gimbal = near_level(open_above);
            default: f.rc_gimbal = rand_level();
        endcase
        return f;
    endfunction

    task automatic queue_frame(
        input logic            failed,
        input logic [CH_W-1:0] ap_e, ap_a, ap_r,
        input logic [CH_W-1:0] rc_e, rc_a, rc_t, rc_r, rc_o, rc_g, rc_v
    );
        t_frame f;
        f = '{failed, ap_e, ap_a, ap_r, rc_e, rc_a, rc_t, rc_r, rc_o, rc_g, rc_v};
        pending_frames.push_back(f);
    endtask

    // Queues random frames on top of whatever is pending and waits until the
    // block has returned every result, so that the registers may be written.
    task automatic run_batch(input int count);
        repeat (count) pending_frames.push_back(rand_frame());
        while (pending_frames.size() != 0 || i_s_axis_tvalid || expected_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    // Writes one register and mirrors it once the write has been accepted.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_OVERRIDE_THR: ovr_thr     = d[CH_W-1:0];
            CFG_REVERSE_THR:  rev_thr     = d[CH_W-1:0];
            CFG_GRAB_CLOSE:   close_below = d[CH_W-1:0];
            CFG_GRAB_OPEN:    open_above  = d[CH_W-1:0];
            CFG_GRAB_POS:     open_pos    = d[PCT_W-1:0];
            CFG_GIMBAL_CTR:   centre_pos  = d[PCT_W-1:0];
            CFG_ELEV_GAIN:    elev_gain   = d[GAIN_W-1:0];
            CFG_RUDDER_GAIN:  rud_gain    = d[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(
        input logic [CFG_DAT_W-1:0] ovr, rev, close_thr, open_thr,
        input logic [CFG_DAT_W-1:0] pos, ctr, eg, rg
    );
        write_reg(CFG_OVERRIDE_THR, ovr);
        write_reg(CFG_REVERSE_THR,  rev);
        write_reg(CFG_GRAB_CLOSE,   close_thr);
        write_reg(CFG_GRAB_OPEN,    open_thr);
        write_reg(CFG_GRAB_POS,     pos);
        write_reg(CFG_GIMBAL_CTR,   ctr);
        write_reg(CFG_ELEV_GAIN,    eg);
        write_reg(CFG_RUDDER_GAIN,  rg);
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers pending frames, with random idle bursts between items.
    // An offered item is held until the block takes it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_frame nxt;
        logic   nxt_valid;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (send_idle_en && $urandom_range(0, 7) == 0) begin
                // Starts an idle burst that also covers this cycle.
                send_gap = $urandom_range(0, 18);
            end else if (pending_frames.size() != 0) begin
                nxt = pending_frames.pop_front();
                nxt_valid = 1'b1;
                i_s_axis_tdata <= {nxt.rc_reverse, nxt.rc_gimbal, nxt.rc_override,
                                   nxt.rc_rudder, nxt.rc_throttle, nxt.rc_aileron,
                                   nxt.rc_elevator, nxt.ap_rudder, nxt.ap_aileron,
                                   nxt.ap_elevator};
                i_s_axis_tuser <= nxt.comms_failed;
            end
            i_s_axis_tvalid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted frame and checks every accepted
    // result. Both happen in this one process so that a prediction is always
    // queued before the result it belongs to is looked at. It also drives the
    // output ready, including one long hold-off that lets the block fill up
    // and push back on its input while the driver keeps offering.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_frame     f;
        t_servo_cmd got;
        t_servo_cmd want;
        logic       nxt_ready;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                f.comms_failed = i_s_axis_tuser;
                f.ap_elevator  = i_s_axis_tdata[7:0];
                f.ap_aileron   = i_s_axis_tdata[15:8];
                f.ap_rudder    = i_s_axis_tdata[23:16];
                f.rc_elevator  = i_s_axis_tdata[31:24];
                f.rc_aileron   = i_s_axis_tdata[39:32];
                f.rc_throttle  = i_s_axis_tdata[47:40];
                f.rc_rudder    = i_s_axis_tdata[55:48];
                f.rc_override  = i_s_axis_tdata[63:56];
                f.rc_gimbal    = i_s_axis_tdata[71:64];
                f.rc_reverse   = i_s_axis_tdata[79:72];
                expected_cmds.push_back(mix_frame(f));
            end

            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.left_tail    = o_m_axis_tdata[6:0];
                got.right_tail   = o_m_axis_tdata[13:7];
                got.aileron_out  = o_m_axis_tdata[20:14];
                got.nose_wheel   = o_m_axis_tdata[27:21];
                got.throttle_out = o_m_axis_tdata[34:28];
                got.gimbal_out   = o_m_axis_tdata[41:35];
                got.grabber_out  = o_m_axis_tdata[48:42];
                got.reverse_led  = o_m_axis_tdata[49];
                if (expected_cmds.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: unexpected result item, expected none, actual %h",
                                 $time, o_m_axis_tdata);
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("left_tail", int'(want.left_tail), int'(got.left_tail));
                    check_field("right_tail", int'(want.right_tail), int'(got.right_tail));
                    check_field("aileron_out", int'(want.aileron_out),
                                int'(got.aileron_out));
                    check_field("nose_wheel", int'(want.nose_wheel), int'(got.nose_wheel));
                    check_field("throttle_out", int'(want.throttle_out),
                                int'(got.throttle_out));
                    check_field("gimbal_out", int'(want.gimbal_out), int'(got.gimbal_out));
                    check_field("grabber_out", int'(want.grabber_out),
                                int'(got.grabber_out));
                    check_field("reverse_led", int'(want.reverse_led),
                                int'(got.reverse_led));
                    check_field("zero fill", 0, int'(o_m_axis_tdata[55:50]));
                end
                results_seen++;
                if (results_seen == HOLD_OFF_AT && !hold_done) begin
                    hold_cnt  = HOLD_OFF_CYCLES;
                    hold_done = 1'b1;
                end
            end

            if (hold_cnt > 0) begin
                hold_cnt--;
                nxt_ready = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                nxt_ready = 1'b0;
            end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 18);
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            i_m_axis_tready <= nxt_ready;
        end
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at the reset register values. The first failsafe
        // frame shows the hold state straight out of reset.
        queue_frame(1, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255);
        queue_frame(0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0);
        queue_frame(0, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255);
        // Failsafe now holds the open grabber and the lit LED.
        queue_frame(1,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0);
        // Override and reverse exactly at their thresholds, then one above.
        queue_frame(0,  10,  20,  30,  90,  80,  70,  60,  50,  50,  50);
        queue_frame(0,  10,  20,  30,  90,  80,  70,  60,  51,  50,  51);
        // Gimbal around the close and open thresholds; in between it holds.
        queue_frame(0,  40,  40,  40,  60,  60,  60,  60,   0,  39,   0);
        queue_frame(0,  40,  40,  40,  60,  60,  60,  60,   0,  40,   0);
        queue_frame(0,  40,  40,  40,  60,  60,  60,  60,   0,  60,   0);
        queue_frame(0,  40,  40,  40,  60,  60,  60,  60,   0,  61,   0);
        queue_frame(1,  40,  40,  40,  60,  60,  60,  60,   0,  30,  90);
        // Mix extremes: sums above 100 and below zero are clamped.
        queue_frame(0, 100, 100, 100,   0,  50,  50, 255,   0,  50,   0);
        queue_frame(0, 100, 100, 100, 255,  50,  50,   0,   0,  50,   0);
        queue_frame(0,   0,   0,   0, 100, 101, 101, 100,   0, 101,   0);
        queue_frame(0,   0,   0,   0, 100, 100, 100, 101,   0,  50,   0);
        // Autopilot selected: the nose wheel still follows the receiver rudder.
        queue_frame(0, 128,  64,   0,   0,   0,  30, 101, 255,  50,   0);
        queue_frame(0,   0, 200, 255,  20,  20,  30,   0, 200,  50,   0);
        // Close the grabber with the LED lit, then fail to hold both.
        queue_frame(0,  50,  50,  50,  50,  50,  50,  50,   0,   0, 255);
        queue_frame(1, 255,   0, 255,   0, 255,   0, 255,   0, 255,   0);
        queue_frame(0,  50,  50,  50,  50,  50,  50,  50,   0, 150,   0);
        queue_frame(1,   0, 255,   0, 255,   0, 255,   0, 255,   0, 255);
        run_batch(250);

        // All registers at their lowest values.
        program_regs(0, 0, 0, 0, 0, 0, 0, 0);
        run_batch(200);

        // All data bits set: thresholds at 255, oversized positions, and
        // gains at nearly twice unity.
        program_regs('1, '1, '1, '1, '1, '1, '1, '1);
        run_batch(200);

        // Override and reverse thresholds and positions at the top of the nominal ranges, with unity gains.
        program_regs(100, 100, 20, 80, 100, 100, 1024, 1024);
        run_batch(200);

        repeat (2) begin
            program_regs(CFG_DAT_W'($urandom_range(0, 255)),
                         CFG_DAT_W'($urandom_range(0, 255)),
                         CFG_DAT_W'($urandom_range(0, 255)),
                         CFG_DAT_W'($urandom_range(0, 255)),
                         CFG_DAT_W'($urandom_range(0, 127)),
                         CFG_DAT_W'($urandom_range(0, 127)),
                         CFG_DAT_W'($urandom_range(0, 2047)),
                         CFG_DAT_W'($urandom_range(0, 1024)));
            run_batch(200);
        end

        // Last stretch runs at full rate on both sides.
        program_regs(CFG_DAT_W'($urandom_range(0, 100)),
                     CFG_DAT_W'($urandom_range(0, 100)),
                     CFG_DAT_W'($urandom_range(0, 60)),
                     CFG_DAT_W'($urandom_range(40, 100)),
                     CFG_DAT_W'($urandom_range(0, 100)),
                     CFG_DAT_W'($urandom_range(0, 100)),
                     CFG_DAT_W'($urandom_range(0, 1024)),
                     CFG_DAT_W'($urandom_range(0, 1024)));
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        run_batch(300);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
